>>> rtl/core/bas_pkg.sv
// Shared types and constants for the bond angle spring force unit.
// Command and status structs between controller and datapath, stream widths.
// No dependencies.
package bas_pkg;

    localparam int IN_W   = 352;  // input tdata width
    localparam int OUT_W  = 384;  // output tdata width
    localparam int GRAD_W = 32;
    localparam int E_W    = 48;
    localparam int CNT_W  = 5;    // 32 steps for root and divide loops
    localparam logic [CNT_W-1:0] LAST_STEP = '1;
    localparam logic [1:0] LAST_IDX = 2'd2;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_PREP,
        OP_SQ_MUL,
        OP_SQ_ACC,
        OP_RT_INIT,
        OP_RT_STEP,
        OP_UD_INIT,
        OP_DV_STEP,
        OP_UD_STORE,
        OP_DT_MUL,
        OP_DT_ACC,
        OP_COS,
        OP_PF_MUL,
        OP_PF,
        OP_W_MUL,
        OP_W,
        OP_G_MUL,
        OP_GD_INIT,
        OP_G_STORE,
        OP_VX,
        OP_E1_MUL,
        OP_E2_MUL,
        OP_E_STORE,
        OP_FIN
    } t_op;

    typedef struct packed {
        t_op        op;
        logic       arm;   // 0: arm A, 1: arm B
        logic [1:0] idx;   // x, y, z
    } t_cmd;

    typedef struct packed {
        logic len_zero;    // one of the arms has zero length
    } t_stat;

endpackage

>>> rtl/core/bond_angle_spring_force_unit.sv
// Bond angle spring force unit: harmonic cosine angle term, gradients and energy.
// Top level joining bas_ctrl and bas_datapath. Depends on bas_pkg.
//
// Usage:
//   Input stream (s_axis): one angle term per item, three positions, the
//   equilibrium cosine and the spring constant in tdata; tlast marks the
//   final term of a batch, after which the running energy sum restarts.
//   Output stream (m_axis): one result per term, nine gradients, term energy
//   and batch total in tdata; tuser[0] flags a zero-length arm.
//   Config: i_cfg_we writes i_cfg_data into the energy enable bit.
// Timing:
//   A term's time to result is set by the two 32-step square roots and the
//   twelve 32-step divides on the one shared divider, plus the multiplies on
//   the single shared multiplier; a zero-length arm skips the divides and all
//   later steps, and energy off skips the energy multiplies. One term is worked
//   on at a time; the next is accepted as soon as the result sits in the output
//   register, even while the receiver stalls it.
// Reset: synchronous active low; clears the sequencer, the output valid and
//   the energy sum, and sets energy enable to 1.
module bond_angle_spring_force_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_axis_tvalid,
    output logic                      o_s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, v_x, v_y, v_z, equil_cos, spring_k, pad
    input  logic [bas_pkg::IN_W-1:0]  i_s_axis_tdata,
    input  logic                      i_s_axis_tlast,
    output logic                      o_m_axis_tvalid,
    input  logic                      i_m_axis_tready,
    // grad_a_x..z, grad_b_x..z, grad_v_x..z, term_energy, total_energy
    output logic [bas_pkg::OUT_W-1:0] o_m_axis_tdata,
    // degenerate
    output logic [0:0]                o_m_axis_tuser,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_data
);

    bas_pkg::t_cmd  cmd;
    bas_pkg::t_stat stat;

    bas_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_valid  (i_s_axis_tvalid),
        .o_s_ready  (o_s_axis_tready),
        .o_m_valid  (o_m_axis_tvalid),
        .i_m_ready  (i_m_axis_tready),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    bas_datapath #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_data  (i_s_axis_tdata),
        .i_in_last  (i_s_axis_tlast),
        .o_stat     (stat),
        .o_res_data (o_m_axis_tdata),
        .o_res_deg  (o_m_axis_tuser[0])
    );

endmodule

>>> rtl/core/bas_datapath.sv
// Datapath: operand registers, one shared 33x33 multiplier, integer square root
// step, restoring divider step and output register. Executes bas_pkg::t_cmd.
// Depends on bas_pkg.
module bas_datapath #(
    parameter int FRAC_BITS = 16
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  bas_pkg::t_cmd            i_cmd,
    input  logic [bas_pkg::IN_W-1:0] i_in_data,
    input  logic                     i_in_last,
    output bas_pkg::t_stat           o_stat,
    output logic [bas_pkg::OUT_W-1:0] o_res_data,
    output logic                     o_res_deg
);

    localparam int DW  = 63 - FRAC_BITS;   // gradient divisor width
    localparam int DSW = DW + 32;          // shifted divisor width
    localparam int SH  = 30 - FRAC_BITS;
    localparam int E_W_L = bas_pkg::E_W;
    localparam logic signed [65:0] COS_LIM  = 66'sd1073741824;
    localparam logic signed [65:0] PREF_LIM = 66'sd2147483647;
    localparam logic signed [31:0] G_MAX = 32'sh7FFFFFFF;
    localparam logic signed [31:0] G_MIN = 32'sh80000000;
    localparam logic [48:0] SUM_MAX = 49'h0FFFFFFFFFFFF;

    logic signed [32:0] r_c_a [3];
    logic signed [32:0] r_c_b [3];
    logic [31:0]        r_m_a [3];
    logic [31:0]        r_m_b [3];
    logic               r_neg_a [3];
    logic               r_neg_b [3];
    logic               r_s_a, r_s_b;
    logic [31:0]        r_len_a, r_len_b;
    logic signed [31:0] r_u_a [3];
    logic signed [31:0] r_u_b [3];
    logic signed [31:0] r_g_a [3];
    logic signed [31:0] r_g_b [3];
    logic signed [31:0] r_g_v [3];
    logic signed [31:0] r_eq;
    logic [30:0]        r_k;
    logic               r_last;
    logic signed [65:0] r_prod;
    logic [63:0]        r_r2, r_rx, r_root, r_bit;
    logic [61:0]        r_num;
    logic [DSW-1:0]     r_ds;
    logic [31:0]        r_q;
    logic               r_gneg, r_ovf;
    logic signed [63:0] r_acc;
    logic signed [31:0] r_dp, r_pref;
    logic signed [32:0] r_delta, r_w;
    logic [32:0]        r_mag;
    logic [E_W_L-1:0]   r_e;
    logic [E_W_L-1:0]   r_sum;
    logic [bas_pkg::OUT_W-1:0] r_out;
    logic               r_out_deg;

    logic [31:0]        m_sel, len_sel;
    logic               s_sel, neg_sel;
    logic signed [31:0] u_self, u_oth;
    logic [DW-1:0]      d_sel;
    logic signed [32:0] mul_a, mul_b;
    logic [63:0]        rt_t;
    logic               dv_ge;
    logic [48:0]        total;
    logic               len_zero;

    function automatic logic signed [65:0] shr30(input logic signed [65:0] v);
        logic signed [65:0] t;
        t = v[65] ? -v : v;
        t = t >>> 30;
        return v[65] ? -t : t;
    endfunction

    function automatic logic signed [65:0] clamp66(input logic signed [65:0] v,
                                                   input logic signed [65:0] lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    function automatic logic signed [31:0] gsat(input logic ovf, input logic neg,
                                                input logic [31:0] q);
        if (ovf) return neg ? G_MIN : G_MAX;
        if (neg) return q[31] ? G_MIN : -$signed(q);
        return q[31] ? G_MAX : $signed(q);
    endfunction

    always_comb begin
        m_sel   = i_cmd.arm ? r_m_b[i_cmd.idx] : r_m_a[i_cmd.idx];
        neg_sel = i_cmd.arm ? r_neg_b[i_cmd.idx] : r_neg_a[i_cmd.idx];
        u_self  = i_cmd.arm ? r_u_b[i_cmd.idx] : r_u_a[i_cmd.idx];
        u_oth   = i_cmd.arm ? r_u_a[i_cmd.idx] : r_u_b[i_cmd.idx];
        len_sel = i_cmd.arm ? r_len_b : r_len_a;
        s_sel   = i_cmd.arm ? r_s_b : r_s_a;
        d_sel   = (DW'(len_sel) << SH) << s_sel;
        rt_t    = r_root + r_bit;
        dv_ge   = DSW'(r_num) >= r_ds;
        total   = {1'b0, r_sum} + {1'b0, r_e};
        if (total > SUM_MAX) total = SUM_MAX;
        len_zero = (r_len_a == '0) || (r_len_b == '0);
    end

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (i_cmd.op)
            bas_pkg::OP_SQ_MUL: begin
                mul_a = $signed({1'b0, m_sel});
                mul_b = $signed({1'b0, m_sel});
            end
            bas_pkg::OP_DT_MUL: begin
                mul_a = 33'(r_u_a[i_cmd.idx]);
                mul_b = 33'(r_u_b[i_cmd.idx]);
            end
            bas_pkg::OP_PF_MUL: begin
                mul_a = $signed({2'b00, r_k});
                mul_b = r_delta;
            end
            bas_pkg::OP_W_MUL: begin
                mul_a = 33'(u_self);
                mul_b = 33'(r_dp);
            end
            bas_pkg::OP_G_MUL: begin
                mul_a = 33'(r_pref);
                mul_b = r_w;
            end
            bas_pkg::OP_E1_MUL: begin
                mul_a = $signed(r_mag);
                mul_b = $signed(r_mag);
            end
            bas_pkg::OP_E2_MUL: begin
                mul_a = $signed({2'b00, r_k});
                mul_b = $signed({1'b0, r_prod[63:32]});
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        unique case (i_cmd.op)
            bas_pkg::OP_LOAD: begin
                for (int i = 0; i < 3; i++) begin
                    r_c_a[i] <= $signed({i_in_data[32*i+31], i_in_data[32*i +: 32]})
                              - $signed({i_in_data[192+32*i+31], i_in_data[192+32*i +: 32]});
                    r_c_b[i] <= $signed({i_in_data[96+32*i+31], i_in_data[96+32*i +: 32]})
                              - $signed({i_in_data[192+32*i+31], i_in_data[192+32*i +: 32]});
                    r_g_a[i] <= '0;
                    r_g_b[i] <= '0;
                    r_g_v[i] <= '0;
                end
                r_eq   <= $signed(i_in_data[319:288]);
                r_k    <= i_in_data[350:320];
                r_last <= i_in_last;
                r_e    <= '0;
                r_acc  <= '0;
                r_r2   <= '0;
            end
            bas_pkg::OP_PREP: begin
                logic [32:0] ma [3];
                logic [32:0] mb [3];
                logic sa, sb;
                sa = 1'b0;
                sb = 1'b0;
                for (int i = 0; i < 3; i++) begin
                    ma[i] = r_c_a[i][32] ? 33'(-r_c_a[i]) : 33'(r_c_a[i]);
                    mb[i] = r_c_b[i][32] ? 33'(-r_c_b[i]) : 33'(r_c_b[i]);
                    sa = sa | ma[i][32] | ma[i][31];
                    sb = sb | mb[i][32] | mb[i][31];
                end
                // an arm with a component of 2^31 or more is halved as a whole
                for (int i = 0; i < 3; i++) begin
                    r_m_a[i]   <= sa ? ma[i][32:1] : ma[i][31:0];
                    r_m_b[i]   <= sb ? mb[i][32:1] : mb[i][31:0];
                    r_neg_a[i] <= r_c_a[i][32];
                    r_neg_b[i] <= r_c_b[i][32];
                end
                r_s_a <= sa;
                r_s_b <= sb;
            end
            bas_pkg::OP_SQ_ACC: r_r2 <= r_r2 + r_prod[63:0];
            bas_pkg::OP_RT_INIT: begin
                r_rx   <= r_r2;
                r_r2   <= '0;
                r_root <= '0;
                r_bit  <= 64'h4000000000000000;
            end
            bas_pkg::OP_RT_STEP: begin
                logic [63:0] root_n;
                if (r_rx >= rt_t) begin
                    r_rx   <= r_rx - rt_t;
                    root_n = (r_root >> 1) + r_bit;
                end else begin
                    root_n = r_root >> 1;
                end
                r_root <= root_n;
                r_bit  <= r_bit >> 2;
                if (i_cmd.arm) r_len_b <= root_n[31:0];
                else r_len_a <= root_n[31:0];
            end
            bas_pkg::OP_UD_INIT: begin
                r_num <= {m_sel, 30'b0};
                r_ds  <= DSW'(len_sel) << 31;
                r_q   <= '0;
            end
            bas_pkg::OP_DV_STEP: begin
                if (dv_ge) r_num <= r_num - r_ds[61:0];
                r_q  <= {r_q[30:0], dv_ge};
                r_ds <= r_ds >> 1;
            end
            bas_pkg::OP_UD_STORE: begin
                if (i_cmd.arm) r_u_b[i_cmd.idx] <= neg_sel ? -$signed(r_q) : $signed(r_q);
                else r_u_a[i_cmd.idx] <= neg_sel ? -$signed(r_q) : $signed(r_q);
            end
            bas_pkg::OP_DT_ACC: r_acc <= r_acc + $signed(r_prod[63:0]);
            bas_pkg::OP_COS: begin
                logic signed [31:0] dp;
                logic signed [32:0] dl;
                dp = 32'(clamp66(shr30(66'(r_acc)), COS_LIM));
                dl = 33'(dp) - 33'(r_eq);
                r_dp    <= dp;
                r_delta <= dl;
                r_mag   <= dl[32] ? 33'(-dl) : 33'(dl);
            end
            bas_pkg::OP_PF: r_pref <= 32'(clamp66(shr30(r_prod), PREF_LIM));
            bas_pkg::OP_W: r_w <= 33'(u_oth) - 33'(shr30(r_prod));
            bas_pkg::OP_GD_INIT: begin
                logic [65:0] mag;
                mag = r_prod[65] ? 66'(-r_prod) : 66'(r_prod);
                r_num  <= mag[61:0];
                r_gneg <= r_prod[65];
                r_ds   <= DSW'(d_sel) << 31;
                // quotient of 2^32 or more saturates whatever its low bits
                r_ovf  <= DSW'(mag[61:0]) >= (DSW'(d_sel) << 32);
                r_q    <= '0;
            end
            bas_pkg::OP_G_STORE: begin
                if (i_cmd.arm) r_g_b[i_cmd.idx] <= gsat(r_ovf, r_gneg, r_q);
                else r_g_a[i_cmd.idx] <= gsat(r_ovf, r_gneg, r_q);
            end
            bas_pkg::OP_VX: begin
                for (int i = 0; i < 3; i++) begin
                    logic signed [65:0] sv;
                    sv = -(66'(r_g_a[i]) + 66'(r_g_b[i]));
                    if (sv > 66'(G_MAX)) r_g_v[i] <= G_MAX;
                    else if (sv < 66'(G_MIN)) r_g_v[i] <= G_MIN;
                    else r_g_v[i] <= 32'(sv);
                end
            end
            bas_pkg::OP_E_STORE: r_e <= E_W_L'(r_prod[62:29]);
            bas_pkg::OP_FIN: begin
                r_out <= {total[47:0], r_e,
                          r_g_v[2], r_g_v[1], r_g_v[0],
                          r_g_b[2], r_g_b[1], r_g_b[0],
                          r_g_a[2], r_g_a[1], r_g_a[0]};
                r_out_deg <= len_zero;
            end
            default: begin
            end
        endcase
    end

    // batch energy sum, restarts after the last term
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_cmd.op == bas_pkg::OP_FIN) begin
            r_sum <= r_last ? '0 : total[47:0];
        end
    end

    assign o_stat.len_zero = len_zero;
    assign o_res_data = r_out;
    assign o_res_deg  = r_out_deg;

endmodule

>>> rtl/core/bas_ctrl.sv
// Controller: one-hot sequencer that issues datapath commands, runs the stream
// handshakes and holds the energy enable register. Depends on bas_pkg.
module bas_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_valid,
    output logic           o_s_ready,
    output logic           o_m_valid,
    input  logic           i_m_ready,
    input  logic           i_cfg_we,
    input  logic           i_cfg_data,
    input  bas_pkg::t_stat i_stat,
    output bas_pkg::t_cmd  o_cmd
);

    typedef enum logic [25:0] {
        S_IDLE = 26'h0000001,
        S_PREP = 26'h0000002,
        S_SQM  = 26'h0000004,
        S_SQA  = 26'h0000008,
        S_RTI  = 26'h0000010,
        S_RTS  = 26'h0000020,
        S_CHK  = 26'h0000040,
        S_UDI  = 26'h0000080,
        S_DVS  = 26'h0000100,
        S_UDS  = 26'h0000200,
        S_DTM  = 26'h0000400,
        S_DTA  = 26'h0000800,
        S_COS  = 26'h0001000,
        S_PFM  = 26'h0002000,
        S_PF   = 26'h0004000,
        S_WM   = 26'h0008000,
        S_W    = 26'h0010000,
        S_GM   = 26'h0020000,
        S_GDI  = 26'h0040000,
        S_GDS  = 26'h0080000,
        S_GS   = 26'h0100000,
        S_VX   = 26'h0200000,
        S_EM1  = 26'h0400000,
        S_EM2  = 26'h0800000,
        S_ES   = 26'h1000000,
        S_FIN  = 26'h2000000
    } t_state;

    t_state r_state, n_state;
    logic r_arm, n_arm;
    logic [1:0] r_idx, n_idx;
    logic [bas_pkg::CNT_W-1:0] r_cnt, n_cnt;
    logic r_out_valid, n_out_valid;
    logic r_energy_en;

    always_comb begin
        n_state     = r_state;
        n_arm       = r_arm;
        n_idx       = r_idx;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && !i_m_ready;
        o_cmd.op    = bas_pkg::OP_NONE;
        o_cmd.arm   = r_arm;
        o_cmd.idx   = r_idx;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_valid) begin
                    o_cmd.op = bas_pkg::OP_LOAD;
                    n_state  = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.op = bas_pkg::OP_PREP;
                n_arm    = 1'b0;
                n_idx    = '0;
                n_state  = S_SQM;
            end
            S_SQM: begin
                o_cmd.op = bas_pkg::OP_SQ_MUL;
                n_state  = S_SQA;
            end
            S_SQA: begin
                o_cmd.op = bas_pkg::OP_SQ_ACC;
                if (r_idx == bas_pkg::LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_RTI;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_SQM;
                end
            end
            S_RTI: begin
                o_cmd.op = bas_pkg::OP_RT_INIT;
                n_cnt    = '0;
                n_state  = S_RTS;
            end
            S_RTS: begin
                o_cmd.op = bas_pkg::OP_RT_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == bas_pkg::LAST_STEP) begin
                    if (!r_arm) begin
                        n_arm   = 1'b1;
                        n_state = S_SQM;
                    end else begin
                        n_state = S_CHK;
                    end
                end
            end
            S_CHK: begin
                n_arm = 1'b0;
                n_idx = '0;
                n_state = i_stat.len_zero ? S_FIN : S_UDI;
            end
            S_UDI: begin
                o_cmd.op = bas_pkg::OP_UD_INIT;
                n_cnt    = '0;
                n_state  = S_DVS;
            end
            S_DVS: begin
                o_cmd.op = bas_pkg::OP_DV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == bas_pkg::LAST_STEP) n_state = S_UDS;
            end
            S_UDS: begin
                o_cmd.op = bas_pkg::OP_UD_STORE;
                n_state  = S_UDI;
                if (r_idx != bas_pkg::LAST_IDX) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx = '0;
                    n_arm = ~r_arm;
                    if (r_arm) n_state = S_DTM;
                end
            end
            S_DTM: begin
                o_cmd.op = bas_pkg::OP_DT_MUL;
                n_state  = S_DTA;
            end
            S_DTA: begin
                o_cmd.op = bas_pkg::OP_DT_ACC;
                if (r_idx == bas_pkg::LAST_IDX) begin
                    n_idx   = '0;
                    n_state = S_COS;
                end else begin
                    n_idx   = r_idx + 2'd1;
                    n_state = S_DTM;
                end
            end
            S_COS: begin
                o_cmd.op = bas_pkg::OP_COS;
                n_state  = S_PFM;
            end
            S_PFM: begin
                o_cmd.op = bas_pkg::OP_PF_MUL;
                n_state  = S_PF;
            end
            S_PF: begin
                o_cmd.op = bas_pkg::OP_PF;
                n_arm    = 1'b0;
                n_idx    = '0;
                n_state  = S_WM;
            end
            S_WM: begin
                o_cmd.op = bas_pkg::OP_W_MUL;
                n_state  = S_W;
            end
            S_W: begin
                o_cmd.op = bas_pkg::OP_W;
                n_state  = S_GM;
            end
            S_GM: begin
                o_cmd.op = bas_pkg::OP_G_MUL;
                n_state  = S_GDI;
            end
            S_GDI: begin
                o_cmd.op = bas_pkg::OP_GD_INIT;
                n_cnt    = '0;
                n_state  = S_GDS;
            end
            S_GDS: begin
                o_cmd.op = bas_pkg::OP_DV_STEP;
                n_cnt    = r_cnt + 1'b1;
                if (r_cnt == bas_pkg::LAST_STEP) n_state = S_GS;
            end
            S_GS: begin
                o_cmd.op = bas_pkg::OP_G_STORE;
                n_state  = S_WM;
                if (r_idx != bas_pkg::LAST_IDX) begin
                    n_idx = r_idx + 2'd1;
                end else begin
                    n_idx = '0;
                    n_arm = ~r_arm;
                    if (r_arm) n_state = S_VX;
                end
            end
            S_VX: begin
                o_cmd.op = bas_pkg::OP_VX;
                n_state  = r_energy_en ? S_EM1 : S_FIN;
            end
            S_EM1: begin
                o_cmd.op = bas_pkg::OP_E1_MUL;
                n_state  = S_EM2;
            end
            S_EM2: begin
                o_cmd.op = bas_pkg::OP_E2_MUL;
                n_state  = S_ES;
            end
            S_ES: begin
                o_cmd.op = bas_pkg::OP_E_STORE;
                n_state  = S_FIN;
            end
            S_FIN: begin
                // wait here only while the output register still holds an item
                if (!r_out_valid || i_m_ready) begin
                    o_cmd.op    = bas_pkg::OP_FIN;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_arm       <= 1'b0;
            r_idx       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_energy_en <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_arm       <= n_arm;
            r_idx       <= n_idx;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_we) r_energy_en <= i_cfg_data;
        end
    end

    assign o_s_ready = (r_state == S_IDLE);
    assign o_m_valid = r_out_valid;

endmodule

>>> rtl/core/bas_checker.sv
// Port-level checks for the bond angle spring force unit, bound to its top.
// Depends on bas_pkg for stream widths.
module bas_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      i_s_axis_tvalid,
    input logic                      o_s_axis_tready,
    input logic                      o_m_axis_tvalid,
    input logic                      i_m_axis_tready,
    input logic [bas_pkg::OUT_W-1:0] o_m_axis_tdata,
    input logic [0:0]                o_m_axis_tuser
);

    // stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("stalled result changed");

    // one term at a time: ready drops right after an accept
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("ready stayed high after accept");

    // zero-length arm gives zero gradients and energy
    a_deg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[0] |->
            o_m_axis_tdata[287:0] == '0 && o_m_axis_tdata[335:288] == '0)
        else $error("degenerate item with nonzero result");

    // batch total includes this term
    a_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> o_m_axis_tdata[335:288] <= o_m_axis_tdata[383:336])
        else $error("total energy below term energy");

endmodule

bind bond_angle_spring_force_unit bas_checker u_bas_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

>>> dv/bas_checker.sv
// Result checker for the bond angle spring force unit: watches both streams,
// predicts each result from the accepted term and compares field by field.
// Depends on bas_pkg for stream widths.
`timescale 1ns / 100ps

module bas_scoreboard #(
    parameter int FRAC_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_valid,
    input  logic                      i_s_ready,
    input  logic [bas_pkg::IN_W-1:0]  i_s_data,
    input  logic                      i_s_last,
    input  logic                      i_m_valid,
    input  logic                      i_m_ready,
    input  logic [bas_pkg::OUT_W-1:0] i_m_data,
    input  logic [0:0]                i_m_user,
    input  logic                      i_cfg_we,
    input  logic                      i_cfg_data,
    output int                        o_errors,
    output int                        o_pending,
    output int                        o_results,
    output int                        o_degenerate
);
    localparam longint SUM_MAX = 64'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [bas_pkg::OUT_W-1:0] data;
        logic                      deg;
    } t_force;

    t_force force_q[$];
    logic   energy_on;
    longint energy_acc;

    function automatic longint trunc_shr(longint v, int n);
        if (v < 0) return -((-v) >>> n);
        return v >>> n;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint unsigned root64(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    // unit vector in Q1.30; returns 0 length for a zero arm
    task automatic arm_dir(input longint c[3], output longint u[3],
                           output longint unsigned len, output int sh);
        longint unsigned m[3], r2;
        r2 = 0;
        sh = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] >= 64'd1 << 31) sh = 1;
        end
        for (int i = 0; i < 3; i++) begin
            m[i] >>= sh;
            r2 += m[i] * m[i];
        end
        len = root64(r2);
        for (int i = 0; i < 3; i++) begin
            u[i] = 0;
            if (len != 0) u[i] = c[i] < 0 ? -longint'((m[i] << 30) / len)
                                          : longint'((m[i] << 30) / len);
        end
    endtask

    task automatic predict_force(input logic [bas_pkg::IN_W-1:0] d, input logic last);
        longint c1[3], c2[3], u1[3], u2[3], ga[3], gb[3], gv[3];
        longint unsigned l1, l2, e, tot, mag, k;
        int s1, s2;
        longint eq, dp, delta, pref, d1, d2, w1, w2, vv;
        t_force f;
        eq = longint'(signed'(d[288 +: 32]));
        k = d[352-32 +: 32] & 64'h7FFF_FFFF;
        e = 0;
        for (int i = 0; i < 3; i++) begin
            vv = longint'(signed'(d[(6 + i) * 32 +: 32]));
            c1[i] = longint'(signed'(d[i * 32 +: 32])) - vv;
            c2[i] = longint'(signed'(d[(3 + i) * 32 +: 32])) - vv;
            ga[i] = 0;
            gb[i] = 0;
            gv[i] = 0;
        end
        arm_dir(c1, u1, l1, s1);
        arm_dir(c2, u2, l2, s2);
        f.deg = (l1 == 0) || (l2 == 0);
        if (!f.deg) begin
            d1 = longint'(l1 << (30 + s1 - FRAC_BITS));
            d2 = longint'(l2 << (30 + s2 - FRAC_BITS));
            dp = 0;
            for (int i = 0; i < 3; i++) dp += u1[i] * u2[i];
            dp = clip(trunc_shr(dp, 30), -(64'sd1 << 30), 64'sd1 << 30);
            delta = dp - eq;
            pref = clip(trunc_shr(longint'(k) * delta, 30),
                        -64'sd2147483647, 64'sd2147483647);
            for (int i = 0; i < 3; i++) begin
                w1 = u2[i] - trunc_shr(u1[i] * dp, 30);
                w2 = u1[i] - trunc_shr(u2[i] * dp, 30);
                ga[i] = clip((pref * w1) / d1, -64'sd2147483648, 64'sd2147483647);
                gb[i] = clip((pref * w2) / d2, -64'sd2147483648, 64'sd2147483647);
                gv[i] = clip(-(ga[i] + gb[i]), -64'sd2147483648, 64'sd2147483647);
            end
            if (energy_on) begin
                mag = delta < 0 ? -delta : delta;
                e = (k * ((mag * mag) >> 32)) >> 29;
                if (e > SUM_MAX) e = SUM_MAX;
            end
        end
        tot = energy_acc + e;
        if (tot > SUM_MAX) tot = SUM_MAX;
        energy_acc = last ? 0 : tot;
        for (int i = 0; i < 3; i++) begin
            f.data[i * 32 +: 32]       = ga[i][31:0];
            f.data[(3 + i) * 32 +: 32] = gb[i][31:0];
            f.data[(6 + i) * 32 +: 32] = gv[i][31:0];
        end
        f.data[288 +: 48] = e[47:0];
        f.data[336 +: 48] = tot[47:0];
        force_q = {force_q, f};
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        o_errors++;
    endtask

    initial begin
        o_errors = 0;
        o_pending = 0;
        o_results = 0;
        o_degenerate = 0;
    end

    always @(posedge i_clk) begin
        t_force f;
        if (!i_rst_n) begin
            energy_on  = 1'b1;
            energy_acc = 0;
        end else begin
            if (i_m_valid && i_m_ready) begin
                if (force_q.size() == 0) begin
                    report_mismatch("unexpected result", 0, 0);
                end else begin
                    f = force_q.pop_front();
                    o_results++;
                    if (f.deg) o_degenerate++;
                    for (int i = 0; i < 9; i++)
                        if (i_m_data[i * 32 +: 32] !== f.data[i * 32 +: 32])
                            report_mismatch($sformatf("gradient %0d", i),
                                            i_m_data[i * 32 +: 32], f.data[i * 32 +: 32]);
                    if (i_m_data[288 +: 48] !== f.data[288 +: 48])
                        report_mismatch("term energy", i_m_data[288 +: 48], f.data[288 +: 48]);
                    if (i_m_data[336 +: 48] !== f.data[336 +: 48])
                        report_mismatch("total energy", i_m_data[336 +: 48], f.data[336 +: 48]);
                    if (i_m_user[0] !== f.deg)
                        report_mismatch("degenerate", i_m_user[0], f.deg);
                end
            end
            if (i_s_valid && i_s_ready) predict_force(i_s_data, i_s_last);
            if (i_cfg_we) energy_on = i_cfg_data;
        end
        o_pending = force_q.size();
    end
endmodule

>>> dv/bond_angle_spring_force_unit_test.sv
// Testbench top for the bond angle spring force unit: drives angle terms in
// bursts, stalls the result stream and gives the verdict. Uses bas_scoreboard.
`timescale 1ns / 100ps

module bond_angle_spring_force_unit_test;
    logic                      i_clk;
    logic                      i_rst_n;
    logic                      s_valid, s_ready, s_last;
    logic [bas_pkg::IN_W-1:0]  s_data;
    logic                      m_valid, m_ready;
    logic [bas_pkg::OUT_W-1:0] m_data;
    logic [0:0]                m_user;
    logic                      cfg_we, cfg_data;
    int                        errors, pending, results, degen;
    int                        terms_sent;

    bond_angle_spring_force_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid), .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data), .i_s_axis_tlast(s_last),
        .o_m_axis_tvalid(m_valid), .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data), .o_m_axis_tuser(m_user),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data)
    );

    bas_scoreboard chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_valid(s_valid), .i_s_ready(s_ready), .i_s_data(s_data), .i_s_last(s_last),
        .i_m_valid(m_valid), .i_m_ready(m_ready), .i_m_data(m_data), .i_m_user(m_user),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_degenerate(degen)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    // receiver: long stalls, short stalls, and free-running stretches
    int stall_mode;
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode = $urandom_range(0, 2);
        case (stall_mode)
            0: m_ready <= 1'b1;
            1: m_ready <= ($urandom_range(0, 3) != 0);
            default: m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    function automatic logic [31:0] rand_coord(int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return 32'(signed'($urandom_range(0, 2000000)) - 1000000);
        endcase
    endfunction

    // valid stays high into the next item when there is no gap
    task automatic send_term(input logic [31:0] pos[9], input logic [31:0] eqc,
                             input logic [30:0] k, input logic last);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? $urandom_range(1, 20) : 0;
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        for (int i = 0; i < 9; i++) s_data[i * 32 +: 32] <= pos[i];
        s_data[288 +: 32] <= eqc;
        s_data[320 +: 32] <= {1'b0, k};
        s_last  <= last;
        s_valid <= 1'b1;
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        terms_sent++;
        @(negedge i_clk);
    endtask

    task automatic random_term(int mode);
        logic [31:0] pos[9];
        logic [31:0] eqc;
        logic [30:0] k;
        for (int i = 0; i < 9; i++) pos[i] = rand_coord(mode);
        if ($urandom_range(0, 19) == 0) pos[$urandom_range(0, 2)] = pos[6];
        if ($urandom_range(0, 19) == 0) pos[3 + $urandom_range(0, 2)] = pos[7];
        if ($urandom_range(0, 39) == 0) begin
            for (int i = 0; i < 3; i++) pos[i] = pos[6 + i];
        end
        eqc = $urandom_range(0, 9) == 0 ? $urandom()
              : 32'(signed'($urandom_range(0, 32'h8000_0000)) - 32'sh4000_0000);
        k = $urandom_range(0, 3) == 0 ? 31'($urandom()) : 31'($urandom_range(0, 1 << 22));
        send_term(pos, eqc, k, $urandom_range(0, 7) == 0);
    endtask

    task automatic drain_and_write(input logic val);
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        cfg_we   <= 1'b1;
        cfg_data <= val;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    initial begin
        logic [31:0] pos[9];
        int mode;
        i_rst_n    = 1'b0;
        s_valid    = 1'b0;
        s_last     = 1'b0;
        s_data     = '0;
        m_ready    = 1'b1;
        stall_mode = 0;
        cfg_we     = 1'b0;
        cfg_data   = 1'b0;
        terms_sent = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: right angle, extremes, zero arms, cosine and spring limits
        pos = '{32'h10000, 0, 0, 0, 32'h10000, 0, 0, 0, 0};
        send_term(pos, 32'h0, 31'h10000, 1'b0);
        send_term(pos, 32'h4000_0000, 31'h7FFF_FFFF, 1'b0);
        send_term(pos, 32'hC000_0000, 31'h7FFF_FFFF, 1'b1);
        pos = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000};
        send_term(pos, 32'h0, 31'h7FFF_FFFF, 1'b0);
        pos = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0};
        send_term(pos, 32'hFFFF_FFFF, 31'h0, 1'b0);
        pos = '{5, 5, 5, 1, 2, 3, 5, 5, 5};
        send_term(pos, 32'h2000_0000, 31'h10000, 1'b0);
        pos = '{1, 2, 3, 5, 5, 5, 5, 5, 5};
        send_term(pos, 32'h2000_0000, 31'h10000, 1'b1);
        pos = '{32'h10000, 0, 0, 32'h20000, 0, 0, 0, 0, 0};
        send_term(pos, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0);
        pos = '{32'h10000, 0, 0, 32'hFFFE_0000, 0, 0, 0, 0, 0};
        send_term(pos, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1);
        pos = '{1, 0, 0, 0, 1, 0, 0, 0, 0};
        send_term(pos, 32'h4000_0000, 31'h1, 1'b0);

        drain_and_write(1'b0);
        for (int n = 0; n < 150; n++) random_term($urandom_range(0, 2));
        drain_and_write(1'b1);
        for (int n = 0; n < 450; n++) begin
            mode = $urandom_range(0, 9) == 0 ? 1 : ($urandom_range(0, 1) ? 0 : 2);
            random_term(mode);
        end
        s_valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(negedge i_clk);
        $display("Sent %0d angle terms, %0d results checked (%0d with a zero arm),",
                 terms_sent, results, degen);
        $display("across both energy settings, extreme coordinates and batch ends.");
        if (errors == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    initial begin
        #30000000;
        $display("*** FAILED ***");
        $finish;
    end
endmodule

>>> files.f
rtl/core/bas_pkg.sv
rtl/core/bas_datapath.sv
rtl/core/bas_ctrl.sv
rtl/core/bond_angle_spring_force_unit.sv
rtl/core/bas_checker.sv
dv/bas_checker.sv
dv/bond_angle_spring_force_unit_test.sv
